[rtl/lprt_pkg.sv]
// ============================================================================
// lprt_pkg
// Shared types, codes and helpers for the longest-prefix route table.
// ============================================================================
package lprt_pkg;

    // default table size
    localparam int TABLE_ENTRIES_DEF = 64;

    // field widths
    localparam int CMD_W    = 2;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 6;
    localparam int IFACE_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_AW   = 3;

    // longest legal prefix
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd3;

    // register index (address bit 2)
    localparam logic REG_DEFAULT_IFACE = 1'b0;
    localparam logic REG_DEFAULT_NH    = 1'b1;

    // one table slot as held in memory
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] prefix;
        logic [LEN_W-1:0]  length;
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0] next_hop;
    } t_entry;

    // one response
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [IFACE_W-1:0]  iface;
        logic [ADDR_W-1:0]   next_hop;
    } t_result;

    // netmask for a prefix length of 0..32
    function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

[rtl/lprt_mem.sv]
// ============================================================================
// lprt_mem
// Route slot memory: one write port, one read port, registered read data.
// ============================================================================
module lprt_mem #(
    parameter int DEPTH = lprt_pkg::TABLE_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  lprt_pkg::t_entry i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output lprt_pkg::t_entry o_rdata
);

    lprt_pkg::t_entry mem [DEPTH];
    lprt_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lprt_cfg.sv]
// ============================================================================
// lprt_cfg
// Register file for the default route, written and read over the bus port.
// ============================================================================
module lprt_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [lprt_pkg::CFG_AW-1:0]  i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic [lprt_pkg::IFACE_W-1:0] o_def_iface,
    output logic [lprt_pkg::ADDR_W-1:0]  o_def_nh
);

    logic [lprt_pkg::IFACE_W-1:0] r_def_iface;
    logic [lprt_pkg::ADDR_W-1:0]  r_def_nh;
    logic                         wr_en;

    assign wr_en = i_psel & i_penable & i_pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_iface <= '0;
            r_def_nh    <= '0;
        end else if (wr_en) begin
            case (i_paddr[2])
                lprt_pkg::REG_DEFAULT_IFACE: r_def_iface <= i_pwdata[lprt_pkg::IFACE_W-1:0];
                lprt_pkg::REG_DEFAULT_NH:    r_def_nh    <= i_pwdata;
                default:                     r_def_nh    <= r_def_nh;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (i_paddr[2])
            lprt_pkg::REG_DEFAULT_IFACE: o_prdata = {28'd0, r_def_iface};
            lprt_pkg::REG_DEFAULT_NH:    o_prdata = r_def_nh;
            default:                     o_prdata = '0;
        endcase
    end

    assign o_def_iface = r_def_iface;
    assign o_def_nh    = r_def_nh;

endmodule

[rtl/lprt_ctrl.sv]
// ============================================================================
// lprt_ctrl
// Command sequencer: clears the table after reset, scans every slot once per
// request to find the key, the first free slot and the longest match, then
// writes back and hands the response on.
// ============================================================================
module lprt_ctrl #(
    parameter int TABLE_ENTRIES = lprt_pkg::TABLE_ENTRIES_DEF,
    parameter int AW            = $clog2(TABLE_ENTRIES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          i_req_valid,
    output logic                          o_idle,
    input  logic [lprt_pkg::CMD_W-1:0]    i_cmd,
    input  logic [lprt_pkg::ADDR_W-1:0]   i_address,
    input  logic [lprt_pkg::LEN_W-1:0]    i_prefix_len,
    input  logic [lprt_pkg::IFACE_W-1:0]  i_iface,
    input  logic [lprt_pkg::ADDR_W-1:0]   i_next_hop,
    // default route
    input  logic [lprt_pkg::IFACE_W-1:0]  i_def_iface,
    input  logic [lprt_pkg::ADDR_W-1:0]   i_def_nh,
    // response side
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output lprt_pkg::t_result             o_res,
    // memory
    output logic                          o_mem_we,
    output logic [AW-1:0]                 o_mem_waddr,
    output lprt_pkg::t_entry              o_mem_wdata,
    output logic                          o_mem_re,
    output logic [AW-1:0]                 o_mem_raddr,
    input  lprt_pkg::t_entry              i_mem_rdata
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [AW:0]   CNT_END = (AW+1)'(TABLE_ENTRIES);
    localparam logic [AW-1:0] IDX_END = AW'(TABLE_ENTRIES - 1);

    logic [1:0]                   r_state, n_state;
    logic [AW:0]                  r_cnt;
    logic                         r_dly_vld;
    logic [AW-1:0]                r_dly_idx;

    logic [lprt_pkg::CMD_W-1:0]   r_cmd;
    logic [lprt_pkg::ADDR_W-1:0]  r_addr;
    logic [lprt_pkg::ADDR_W-1:0]  r_key;
    logic [lprt_pkg::LEN_W-1:0]   r_len;
    logic [lprt_pkg::IFACE_W-1:0] r_iface;
    logic [lprt_pkg::ADDR_W-1:0]  r_nh;

    logic                         r_found;
    logic [AW-1:0]                r_found_idx;
    logic                         r_free;
    logic [AW-1:0]                r_free_idx;
    logic                         r_best;
    logic [lprt_pkg::LEN_W-1:0]   r_best_len;
    logic [lprt_pkg::IFACE_W-1:0] r_best_iface;
    logic [lprt_pkg::ADDR_W-1:0]  r_best_nh;

    logic [lprt_pkg::LEN_W-1:0]   req_len;
    logic                         key_hit;
    logic                         lpm_hit;
    logic                         wb_add;
    logic                         wb_del;
    logic                         leave_done;

    // clamp the prefix length on entry
    assign req_len = (i_prefix_len > lprt_pkg::MAX_LEN) ? lprt_pkg::MAX_LEN : i_prefix_len;

    // compare the slot that came back from memory
    assign key_hit = i_mem_rdata.valid && (i_mem_rdata.length == r_len)
                     && (i_mem_rdata.prefix == r_key);
    assign lpm_hit = i_mem_rdata.valid
                     && ((r_addr & lprt_pkg::len_mask(i_mem_rdata.length)) == i_mem_rdata.prefix)
                     && (!r_best || (i_mem_rdata.length > r_best_len));

    // write-back decision
    assign leave_done = (r_state == ST_DONE) && i_res_ready;
    assign wb_add     = (r_cmd == lprt_pkg::CMD_ADD) && !r_found && r_free;
    assign wb_del     = (r_cmd == lprt_pkg::CMD_DEL) && r_found;

    // memory port drive
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt[AW-1:0];
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_cnt[AW-1:0];
        case (r_state)
            ST_CLEAR: begin
                o_mem_we = 1'b1;
            end
            ST_SCAN: begin
                o_mem_re = (r_cnt != CNT_END);
            end
            ST_DONE: begin
                o_mem_we    = leave_done && (wb_add || wb_del);
                o_mem_waddr = wb_add ? r_free_idx : r_found_idx;
                if (wb_add) begin
                    o_mem_wdata.valid    = 1'b1;
                    o_mem_wdata.prefix   = r_key;
                    o_mem_wdata.length   = r_len;
                    o_mem_wdata.iface    = r_iface;
                    o_mem_wdata.next_hop = r_nh;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_cnt[AW-1:0] == IDX_END) n_state = ST_IDLE;
            ST_IDLE:  if (i_req_valid) n_state = ST_SCAN;
            ST_SCAN:  if (!o_mem_re && !r_dly_vld) n_state = ST_DONE;
            ST_DONE:  if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_dly_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free    <= 1'b0;
            r_best    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dly_vld <= o_mem_re;
            if (r_state == ST_CLEAR || o_mem_re) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == ST_IDLE) begin
                r_cnt <= '0;
            end
            if (r_state == ST_IDLE && i_req_valid) begin
                r_found <= 1'b0;
                r_free  <= 1'b0;
                r_best  <= 1'b0;
            end else if (r_dly_vld) begin
                if (key_hit && !r_found) r_found <= 1'b1;
                if (!i_mem_rdata.valid && !r_free) r_free <= 1'b1;
                if (lpm_hit) r_best <= 1'b1;
            end
        end
    end

    // request capture and scan results
    always_ff @(posedge i_clk) begin
        r_dly_idx <= r_cnt[AW-1:0];
        if (r_state == ST_IDLE && i_req_valid) begin
            r_cmd   <= i_cmd;
            r_addr  <= i_address;
            r_len   <= req_len;
            r_key   <= i_address & lprt_pkg::len_mask(req_len);
            r_iface <= i_iface;
            r_nh    <= i_next_hop;
        end
        if (r_dly_vld) begin
            if (key_hit && !r_found) r_found_idx <= r_dly_idx;
            if (!i_mem_rdata.valid && !r_free) r_free_idx <= r_dly_idx;
            if (lpm_hit) begin
                r_best_len   <= i_mem_rdata.length;
                r_best_iface <= i_mem_rdata.iface;
                r_best_nh    <= i_mem_rdata.next_hop;
            end
        end
    end

    // response build
    always_comb begin
        o_res = '0;
        case (r_cmd)
            lprt_pkg::CMD_ADD: begin
                if (r_found)     o_res.status = lprt_pkg::STATUS_DUP;
                else if (r_free) o_res.status = lprt_pkg::STATUS_DONE;
                else             o_res.status = lprt_pkg::STATUS_FULL;
            end
            lprt_pkg::CMD_DEL: begin
                o_res.status = r_found ? lprt_pkg::STATUS_DONE : lprt_pkg::STATUS_ABSENT;
            end
            lprt_pkg::CMD_LOOKUP: begin
                o_res.hit      = r_best;
                o_res.iface    = r_best ? r_best_iface : i_def_iface;
                o_res.next_hop = r_best ? r_best_nh : i_def_nh;
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid = (r_state == ST_DONE);
    assign o_idle      = (r_state == ST_IDLE);

endmodule

[rtl/longest_prefix_route_table.sv]
// ============================================================================
// longest_prefix_route_table
// IPv4 route table with add, delete and longest-prefix lookup.
// ============================================================================
// Requests enter on the slave stream: tuser carries the command (add, delete,
// lookup), tdata the address, prefix length, interface and next hop. Each
// request produces one response on the master stream: tuser carries status
// and hit, tdata the chosen interface and next hop. The default route for a
// lookup that matches nothing sits in two registers on the bus port.
// Every request is one full pass over the slot memory, one read per cycle.
// The single read port of the slot memory sets the pace; one request is in
// work at a time, and a new request is taken only after the last response
// has gone into the output register.
// After reset a clearing pass marks every slot free; no request is taken
// during it, register writes are taken as usual.
// The response sits in an output register: while the receiver stalls, the
// next request is still accepted and scanned, and it waits at the end of its
// scan until the output register frees up.
// ============================================================================
module longest_prefix_route_table #(
    parameter int TABLE_ENTRIES = lprt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [79:0]                  i_s_tdata,  // address, prefix_len, iface, next_hop
    input  logic [1:0]                   i_s_tuser,  // cmd
    // response stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [39:0]                  o_m_tdata,  // out_iface, out_next_hop
    output logic [2:0]                   o_m_tuser,  // status, hit
    // register port
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [lprt_pkg::CFG_AW-1:0]  i_paddr,
    input  logic [31:0]                  i_pwdata,
    output logic [31:0]                  o_prdata,
    output logic                         o_pready
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    logic                         s_accept;
    logic                         ctrl_idle;
    logic [lprt_pkg::IFACE_W-1:0] def_iface;
    logic [lprt_pkg::ADDR_W-1:0]  def_nh;
    logic                         res_valid;
    logic                         res_ready;
    lprt_pkg::t_result            res;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    lprt_pkg::t_entry             mem_wdata;
    logic                         mem_re;
    logic [AW-1:0]                mem_raddr;
    lprt_pkg::t_entry             mem_rdata;
    logic                         r_out_vld;
    lprt_pkg::t_result            r_out;

    assign s_accept   = i_s_tvalid & o_s_tready;
    assign o_s_tready = ctrl_idle;
    assign o_pready   = 1'b1;

    // default route registers
    lprt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_def_iface (def_iface),
        .o_def_nh    (def_nh)
    );

    // slot memory
    lprt_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // scan sequencer
    lprt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_accept),
        .o_idle       (ctrl_idle),
        .i_cmd        (i_s_tuser),
        .i_address    (i_s_tdata[31:0]),
        .i_prefix_len (i_s_tdata[37:32]),
        .i_iface      (i_s_tdata[41:38]),
        .i_next_hop   (i_s_tdata[73:42]),
        .i_def_iface  (def_iface),
        .i_def_nh     (def_nh),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    // output register
    assign res_ready = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {4'd0, r_out.next_hop, r_out.iface};
    assign o_m_tuser  = {r_out.hit, r_out.status};

    // memory is never read and written in the same cycle
    a_mem_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("slot memory read and write collide");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("request accepted while another is in work");

    // a hit only comes with a done status
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tuser[1:0] == lprt_pkg::STATUS_DONE))
        else $error("hit reported with a non-done status");

    // a handed-over response shows up on the port
    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> o_m_tvalid)
        else $error("response lost at the output register");

endmodule

[dv/longest_prefix_route_table_tb.sv]
// ============================================================================
// longest_prefix_route_table_tb
// Self-checking bench for the longest-prefix route table.
// ============================================================================
// Add, delete, lookup and the unused command code are sent on the request
// stream. An in-bench route table predicts each response when its request
// is accepted, and the response monitor checks status, hit, interface and
// next hop in order. A short directed list covers the corner cases. Random
// phases then fill, drain and probe the table with keys drawn from a pool
// of recent prefixes. The default route registers are rewritten between
// phases. Both stream sides idle at random, and one long receiver hold-off
// fills the pipeline.
// ============================================================================
module longest_prefix_route_table_tb;
    import lprt_pkg::*;

    localparam int TABLE_SLOTS = TABLE_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 600;
    localparam int POOL_MAX    = 80;
    localparam int PRINT_MAX   = 40;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    // one request as it travels on the request stream
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   plen;
        logic [IFACE_W-1:0] iface;
        logic [ADDR_W-1:0]  nh;
    } route_req_t;

    // a prefix that random requests reuse
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  plen;
    } pool_key_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        o_m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    // predicted route table and default route
    logic               rt_valid [TABLE_SLOTS];
    logic [ADDR_W-1:0]  rt_prefix [TABLE_SLOTS];
    logic [LEN_W-1:0]   rt_len [TABLE_SLOTS];
    logic [IFACE_W-1:0] rt_iface [TABLE_SLOTS];
    logic [ADDR_W-1:0]  rt_nh [TABLE_SLOTS];
    logic [IFACE_W-1:0] dflt_iface = '0;
    logic [ADDR_W-1:0]  dflt_nh = '0;

    route_req_t pending_reqs [$];
    t_result    due_results [$];
    pool_key_t  key_pool [$];
    route_req_t cur_req = '0;

    int  err_count = 0;
    int  resp_count = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    bit  gap_en = 1'b1;
    bit  stall_en = 1'b1;

    longest_prefix_route_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // address, prefix_len, iface, next_hop
        .i_s_tuser  (s_tuser),    // cmd
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),  // out_iface, out_next_hop
        .o_m_tuser  (o_m_tuser),  // status, hit
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= PRINT_MAX)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // netmask, lengths above 32 count as 32
    function automatic logic [ADDR_W-1:0] net_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] l;
        l = (len > MAX_LEN) ? MAX_LEN : len;
        if (l == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - l);
    endfunction

    function automatic int find_route(input logic [ADDR_W-1:0] key,
                                      input logic [LEN_W-1:0] len);
        for (int k = 0; k < TABLE_SLOTS; k++)
            if (rt_valid[k] && rt_len[k] == len && rt_prefix[k] == key)
                return k;
        return -1;
    endfunction

    // apply one request to the predicted table, return its response
    function automatic t_result predict_route(input route_req_t r);
        t_result          res;
        logic [LEN_W-1:0] len;
        logic [ADDR_W-1:0] key;
        int               slot;
        int               best;
        bit               placed;
        res = '0;
        len = (r.plen > MAX_LEN) ? MAX_LEN : r.plen;
        key = r.addr & net_mask(len);
        case (r.cmd)
            CMD_ADD: begin
                if (find_route(key, len) >= 0) begin
                    res.status = STATUS_DUP;
                end else begin
                    placed = 1'b0;
                    for (int k = 0; k < TABLE_SLOTS; k++) begin
                        if (!placed && !rt_valid[k]) begin
                            rt_valid[k]  = 1'b1;
                            rt_prefix[k] = key;
                            rt_len[k]    = len;
                            rt_iface[k]  = r.iface;
                            rt_nh[k]     = r.nh;
                            placed = 1'b1;
                        end
                    end
                    res.status = placed ? STATUS_DONE : STATUS_FULL;
                end
            end
            CMD_DEL: begin
                slot = find_route(key, len);
                if (slot >= 0)
                    rt_valid[slot] = 1'b0;
                else
                    res.status = STATUS_ABSENT;
            end
            CMD_LOOKUP: begin
                best = -1;
                for (int k = 0; k < TABLE_SLOTS; k++) begin
                    if (rt_valid[k] && (r.addr & net_mask(rt_len[k])) == rt_prefix[k]
                        && (best < 0 || rt_len[k] > rt_len[best]))
                        best = k;
                end
                if (best >= 0) begin
                    res.hit      = 1'b1;
                    res.iface    = rt_iface[best];
                    res.next_hop = rt_nh[best];
                end else begin
                    res.iface    = dflt_iface;
                    res.next_hop = dflt_nh;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic route_req_t make_req(input logic [CMD_W-1:0] cmd,
                                            input logic [ADDR_W-1:0] addr,
                                            input logic [LEN_W-1:0] plen,
                                            input logic [IFACE_W-1:0] iface,
                                            input logic [ADDR_W-1:0] nh);
        route_req_t r;
        r.cmd   = cmd;
        r.addr  = addr;
        r.plen  = plen;
        r.iface = iface;
        r.nh    = nh;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 100);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic vld;
        vld = s_tvalid;
        if (s_tvalid && o_s_tready) begin
            due_results.push_back(predict_route(cur_req));
            vld = 1'b0;
        end
        if (!vld && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                cur_req  = pending_reqs.pop_front();
                vld      = 1'b1;
                gap_left = gap_en ? pick_gap() : 0;
            end
        end
        s_tvalid <= vld;
        s_tdata  <= {6'b0, cur_req.nh, cur_req.iface, cur_req.plen, cur_req.addr};
        s_tuser  <= cur_req.cmd;
    end

    // response monitor and receiver stalls
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    rdy;
        if (o_m_tvalid && m_tready) begin
            got.status   = o_m_tuser[1:0];
            got.hit      = o_m_tuser[2];
            got.iface    = o_m_tdata[3:0];
            got.next_hop = o_m_tdata[35:4];
            if (due_results.size() == 0) begin
                report_error($sformatf("response %0d with nothing outstanding: %p",
                                       resp_count, got));
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                    report_error($sformatf("response %0d status %0d, predicted %0d",
                                           resp_count, got.status, want.status));
                if (got.hit !== want.hit)
                    report_error($sformatf("response %0d hit %0b, predicted %0b",
                                           resp_count, got.hit, want.hit));
                if (got.iface !== want.iface)
                    report_error($sformatf("response %0d iface %0d, predicted %0d",
                                           resp_count, got.iface, want.iface));
                if (got.next_hop !== want.next_hop)
                    report_error($sformatf("response %0d next hop %h, predicted %h",
                                           resp_count, got.next_hop, want.next_hop));
            end
            resp_count++;
        end
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (stall_en && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap();
            rdy = (stall_left == 0);
        end else begin
            rdy = 1'b1;
        end
        m_tready <= rdy;
    end

    // wait until every request is sent and answered
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || s_tvalid || due_results.size() != 0);
    endtask

    // bus write, only while the block is idle
    task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!o_pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_DEFAULT_IFACE)
            dflt_iface = value[IFACE_W-1:0];
        else
            dflt_nh = value;
    endtask

    // random requests around a pool of recent prefixes
    task automatic run_random_phase(input int count, input int add_w,
                                    input int del_w, input bit idle_en);
        route_req_t        r;
        pool_key_t         pk;
        int                roll;
        logic [ADDR_W-1:0] m;
        @(negedge i_clk);
        gap_en   = idle_en;
        stall_en = idle_en;
        repeat (count) begin
            r.addr  = $urandom;
            r.iface = IFACE_W'($urandom);
            r.nh    = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                r.plen = '0;
            else if (roll < 13)
                r.plen = LEN_W'($urandom_range(33, 63));
            else if (roll < 23)
                r.plen = MAX_LEN;
            else
                r.plen = LEN_W'($urandom_range(1, 31));
            pk = '0;
            if (key_pool.size() > 0)
                pk = key_pool[$urandom_range(0, key_pool.size() - 1)];
            m = net_mask(pk.plen);
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                r.cmd = CMD_NONE;
            end else if (roll < 3 + add_w) begin
                r.cmd = CMD_ADD;
                // duplicate key or a longer prefix nested inside a known one
                if (key_pool.size() > 0 && $urandom_range(0, 3) == 0) begin
                    r.addr = (pk.addr & m) | (r.addr & ~m);
                    if ($urandom_range(0, 1) == 0)
                        r.plen = pk.plen;
                    else if (pk.plen + 8 >= MAX_LEN)
                        r.plen = MAX_LEN;
                    else
                        r.plen = LEN_W'(pk.plen + $urandom_range(1, 8));
                end
                key_pool.push_back({r.addr, r.plen});
                if (key_pool.size() > POOL_MAX)
                    void'(key_pool.pop_front());
            end else if (roll < 3 + add_w + del_w) begin
                r.cmd = CMD_DEL;
                if (key_pool.size() > 0 && $urandom_range(0, 9) != 0) begin
                    r.addr = (pk.addr & m) | (r.addr & ~m);
                    r.plen = pk.plen;
                end
            end else begin
                r.cmd = CMD_LOOKUP;
                if (key_pool.size() > 0 && $urandom_range(0, 4) != 0)
                    r.addr = (pk.addr & m) | (r.addr & ~m);
            end
            pending_reqs.push_back(r);
        end
        drain();
    endtask

    // main sequence
    initial begin
        int add_mix [8] = '{35, 70, 15, 10, 75, 35, 15, 35};
        int del_mix [8] = '{20,  5, 10, 60,  5, 20, 55, 25};
        logic [31:0] if_val;
        logic [31:0] nh_val;
        for (int k = 0; k < TABLE_SLOTS; k++)
            rt_valid[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default route straight out of reset
        @(negedge i_clk);
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'hC0A8_0101, 6'd0, 4'd0, 32'h0));
        drain();
        cfg_write(REG_DEFAULT_IFACE, 32'hFFFF_FFFF);
        cfg_write(REG_DEFAULT_NH, 32'hFFFF_FFFF);

        // directed corner cases
        @(negedge i_clk);
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A01_0203, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0A12_3456, 6'd8,  4'd1, 32'h0A00_00FE));
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0A01_FFFF, 6'd16, 4'd2, 32'h0A01_0001));
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0A01_0203, 6'd32, 4'd3, 32'hC0A8_0001));
        // zero length key matches everything
        pending_reqs.push_back(make_req(CMD_ADD,    32'hDEAD_BEEF, 6'd0,  4'd4, 32'h0000_0001));
        // oversized length aliases /32, existing key kept
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0A01_0203, 6'd40, 4'd9, 32'h0));
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0AFF_0000, 6'd8,  4'd5, 32'h1234_5678));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A01_0203, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A01_0909, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A09_0909, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0B00_0000, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_DEL,    32'h0A01_0000, 6'd16, 4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_DEL,    32'h0A01_1234, 6'd16, 4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0A01_0909, 6'd0,  4'd0, 32'h0));
        // unused command code leaves the table alone
        pending_reqs.push_back(make_req(CMD_NONE,   32'hFFFF_FFFF, 6'd63, 4'd15, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_ADD,    32'hFFFF_FFFF, 6'd63, 4'd15, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_ADD,    32'h0000_0000, 6'd32, 4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0000_0000, 6'd63, 4'd15, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(CMD_DEL,    32'h1234_5678, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'h0B00_0000, 6'd0,  4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_DEL,    32'hFFFF_FFFF, 6'd32, 4'd0, 32'h0));
        pending_reqs.push_back(make_req(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0,  4'd0, 32'h0));
        drain();

        // long receiver hold-off while requests keep coming
        @(negedge i_clk);
        hold_requests++;
        gap_en = 1'b0;
        for (int i = 0; i < 12; i++)
            pending_reqs.push_back(make_req((i % 2) ? CMD_LOOKUP : CMD_ADD, $urandom,
                                            LEN_W'($urandom_range(8, 24)),
                                            IFACE_W'($urandom), $urandom));
        drain();

        // random phases, default route rewritten in between
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin if_val = 32'h0;           nh_val = 32'h0;          end
                2: begin if_val = 32'hFFFF_FFFF;   nh_val = 32'h0;          end
                3: begin if_val = 32'hFFFF_FFF0;   nh_val = 32'hFFFF_FFFF;  end
                5: begin if_val = 32'hF;           nh_val = 32'h8000_0001;  end
                7: begin if_val = 32'h0;           nh_val = 32'hFFFF_FFFF;  end
                default: begin if_val = $urandom;  nh_val = $urandom;       end
            endcase
            cfg_write(REG_DEFAULT_IFACE, if_val);
            cfg_write(REG_DEFAULT_NH, nh_val);
            run_random_phase(200, add_mix[p], del_mix[p], p != 5);
        end

        repeat (TABLE_SLOTS + 16) @(posedge i_clk);
        if (due_results.size() != 0)
            report_error($sformatf("%0d responses never arrived", due_results.size()));
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
rtl/lprt_pkg.sv
rtl/lprt_mem.sv
rtl/lprt_cfg.sv
rtl/lprt_ctrl.sv
rtl/longest_prefix_route_table.sv
dv/longest_prefix_route_table_tb.sv
